### src/set_associative_cache_lookup_assert.svh
// Assertion macros used by the checker file.
`ifndef SET_ASSOCIATIVE_CACHE_LOOKUP_ASSERT_SVH
`define SET_ASSOCIATIVE_CACHE_LOOKUP_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define SACL_ASSERT_IMP(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SACL_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

### src/sacl_pkg.sv
`timescale 1ns / 1ps

package sacl_pkg;
    localparam int SETS = 64;
    localparam int WAYS = 8;
    localparam int ADDRESS_BITS = 32;
    localparam int SET_W = $clog2(SETS);
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LINE_W = SET_W + WAY_W;
    localparam int LINES = SETS * WAYS;
    localparam int CNT_W = 16;
    localparam int TAG_W = ADDRESS_BITS;

    // Configuration register indexes.
    localparam logic [1:0] CFG_OFFSET = 2'd0;
    localparam logic [1:0] CFG_INDEX = 2'd1;
    localparam logic [1:0] CFG_WAYS = 2'd2;
    localparam logic [1:0] CFG_POLICY = 2'd3;

    // Policy codes. The spare code behaves as LRU.
    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_LRU = 2'd1;
    localparam logic [1:0] POL_LFU = 2'd2;
    localparam logic [1:0] POL_SPARE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic read;
        logic scan;
        logic write;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
    } stat_t;
endpackage

### src/sacl_ctrl.sv
`timescale 1ns / 1ps

module sacl_ctrl import sacl_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_fire,
    input  logic out_fire,
    input  stat_t stat,
    output cmd_t cmd,
    output logic s_ready,
    output logic m_valid
);
    state_t state_reg, state_next;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_READ;
            ST_READ: state_next = ST_SCAN;
            ST_SCAN: if (stat.scan_done) state_next = ST_WRITE;
            ST_WRITE: state_next = ST_OUT;
            ST_OUT: if (out_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                cmd.start = in_fire;
            end
            ST_READ: cmd.read = 1'b1;
            ST_SCAN: cmd.scan = 1'b1;
            ST_WRITE: cmd.write = 1'b1;
            ST_OUT: m_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

### src/sacl_datapath.sv
`timescale 1ns / 1ps

module sacl_datapath import sacl_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  cmd_t cmd,
    output stat_t stat,
    input  logic [ADDRESS_BITS-1:0] s_address,
    input  logic cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data,
    output logic m_hit,
    output logic [5:0] m_set_index,
    output logic [2:0] m_way,
    output logic m_evicted,
    output logic [31:0] m_hit_count,
    output logic [31:0] m_miss_count
);
    localparam int MAXIB = SET_W;

    // Configuration registers.
    logic [3:0] offset_reg;
    logic [2:0] index_reg;
    logic [3:0] ways_reg;
    logic [1:0] policy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= 4'd4;
            index_reg <= 3'd6;
            ways_reg <= 4'd8;
            policy_reg <= POL_LRU;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_OFFSET: offset_reg <= cfg_data;
                CFG_INDEX: index_reg <= cfg_data[2:0];
                CFG_WAYS: ways_reg <= cfg_data;
                CFG_POLICY: policy_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Effective configuration.
    logic [4:0] nways;
    logic [2:0] ib;
    logic [1:0] mode;
    always_comb begin
        if (ways_reg == 4'd0) nways = 5'd1;
        else if ({1'b0, ways_reg} > 5'(WAYS)) nways = 5'(WAYS);
        else nways = {1'b0, ways_reg};
        ib = (32'(index_reg) > 32'(MAXIB)) ? 3'(MAXIB) : index_reg;
        mode = (policy_reg == POL_SPARE) ? POL_LRU : policy_reg;
    end

    // Address split at the start.
    logic [TAG_W-1:0] tag_reg;
    logic [SET_W-1:0] set_reg;
    logic [ADDRESS_BITS-1:0] block_w;
    assign block_w = s_address >> offset_reg;

    // Per-set state: memories addressed by set, one row of all ways each.
    logic [WAYS*TAG_W-1:0] tag_mem [SETS];
    logic [WAYS-1:0] valid_reg [SETS];
    logic [WAYS*3-1:0] rank_mem [SETS];
    logic [WAYS*CNT_W-1:0] cnt_mem [SETS];
    logic [SETS-1:0] row_ok_reg;

    logic [WAYS*TAG_W-1:0] tag_row_reg;
    logic [WAYS*3-1:0] rank_rd_reg;
    logic [WAYS*CNT_W-1:0] cnt_rd_reg;
    logic [WAYS-1:0] vrow_reg;
    logic ok_reg;

    // Working copy during scan.
    logic [WAY_W-1:0] i_reg;
    logic hit_reg, found_reg, evict_reg;
    logic [WAY_W-1:0] w_reg, inv_reg, vic_reg;
    logic [WAY_W-1:0] w_sel;
    logic [CNT_W-1:0] cnt_row_w [WAYS];
    logic [2:0] rank_row_w [WAYS];

    always_comb begin
        for (int k = 0; k < WAYS; k++) begin
            cnt_row_w[k] = ok_reg ? cnt_rd_reg[k*CNT_W +: CNT_W] : '0;
            rank_row_w[k] = ok_reg ? rank_rd_reg[k*3 +: 3] : '0;
        end
    end

    logic [TAG_W-1:0] cur_tag;
    logic cur_valid;
    logic last_i;
    assign cur_tag = tag_row_reg[i_reg*TAG_W +: TAG_W];
    assign cur_valid = vrow_reg[i_reg];
    assign last_i = ({1'b0, 4'(i_reg)} + 5'd1) >= nways;
    assign stat.scan_done = last_i || (cur_valid && cur_tag == tag_reg);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            set_reg <= SET_W'(block_w & ((32'd1 << ib) - 32'd1));
            tag_reg <= TAG_W'(block_w >> ib);
        end
        if (cmd.read) begin
            tag_row_reg <= tag_mem[set_reg];
            rank_rd_reg <= rank_mem[set_reg];
            cnt_rd_reg <= cnt_mem[set_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_ok_reg <= '0;
            for (int s = 0; s < SETS; s++) valid_reg[s] <= '0;
            vrow_reg <= '0;
            ok_reg <= 1'b0;
        end else if (cmd.read) begin
            vrow_reg <= valid_reg[set_reg];
            ok_reg <= row_ok_reg[set_reg];
        end else if (cmd.write) begin
            valid_reg[set_reg][w_sel] <= 1'b1;
            row_ok_reg[set_reg] <= 1'b1;
        end
    end

    // Scan one way per cycle: hit test, first invalid, policy victim.
    assign w_sel = hit_reg ? w_reg : (found_reg ? inv_reg : vic_reg);

    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            i_reg <= '0;
            hit_reg <= 1'b0;
            found_reg <= 1'b0;
            vic_reg <= '0;
        end else if (cmd.scan) begin
            if (cur_valid && cur_tag == tag_reg) begin
                hit_reg <= 1'b1;
                w_reg <= i_reg;
            end
            if (!cur_valid && !found_reg) begin
                found_reg <= 1'b1;
                inv_reg <= i_reg;
            end
            if (i_reg != '0) begin
                if (mode == POL_LFU) begin
                    if (cnt_row_w[i_reg] < cnt_row_w[vic_reg]) vic_reg <= i_reg;
                end else begin
                    if (rank_row_w[i_reg] < rank_row_w[vic_reg]) vic_reg <= i_reg;
                end
            end
            if (!stat.scan_done) i_reg <= i_reg + 1'b1;
        end else if (cmd.write) begin
            w_reg <= w_sel;
        end
    end

    // Write back: counts, ranks, tag and totals.
    logic [31:0] hit_tot_reg, miss_tot_reg;
    logic [WAYS*3-1:0] rank_new;
    logic [WAYS*CNT_W-1:0] cnt_new;
    logic was_valid, do_rank, miss;
    logic [2:0] others, old_rank;
    always_comb begin
        miss = !hit_reg;
        was_valid = hit_reg || !found_reg;
        do_rank = miss || (mode == POL_LRU);
        old_rank = rank_row_w[w_sel];
        others = '0;
        for (int k = 0; k < WAYS; k++) begin
            rank_new[k*3 +: 3] = rank_row_w[k];
            cnt_new[k*CNT_W +: CNT_W] = cnt_row_w[k];
        end
        for (int k = 0; k < WAYS; k++) begin
            if (k < 32'(nways) && k != 32'(w_sel) && vrow_reg[k]) begin
                others = others + 3'd1;
                if (do_rank && was_valid && rank_row_w[k] > old_rank)
                    rank_new[k*3 +: 3] = rank_row_w[k] - 3'd1;
            end
        end
        if (do_rank) rank_new[32'(w_sel)*3 +: 3] = others;
        if (miss) cnt_new[32'(w_sel)*CNT_W +: CNT_W] = CNT_W'(1);
        else if (cnt_row_w[w_sel] != '1)
            cnt_new[32'(w_sel)*CNT_W +: CNT_W] = cnt_row_w[w_sel] + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            rank_mem[set_reg] <= rank_new;
            cnt_mem[set_reg] <= cnt_new;
            if (miss) tag_mem[set_reg][32'(w_sel)*TAG_W +: TAG_W] <= tag_reg;
            evict_reg <= miss && !found_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_tot_reg <= '0;
            miss_tot_reg <= '0;
        end else if (cmd.write) begin
            if (hit_reg && hit_tot_reg != '1) hit_tot_reg <= hit_tot_reg + 1'b1;
            if (miss && miss_tot_reg != '1) miss_tot_reg <= miss_tot_reg + 1'b1;
        end
    end

    assign m_hit = hit_reg;
    assign m_set_index = 6'(set_reg);
    assign m_way = 3'(w_reg);
    assign m_evicted = evict_reg;
    assign m_hit_count = hit_tot_reg;
    assign m_miss_count = miss_tot_reg;
endmodule

### src/set_associative_cache_lookup.sv
`timescale 1ns / 1ps

// Set-associative cache lookup with FIFO, LRU or LFU replacement. One address word
// is taken at a time; its set row is read, and the shared tag compare then steps
// through the ways in use one at a time until a hit or the end of the set, before
// the row is written back and the result word is presented. The result waits in
// registers until taken, and the next word can be taken in the cycle after that.
// Valid bits reset at once; no clearing pass.
module set_associative_cache_lookup import sacl_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic [ADDRESS_BITS-1:0] s_address,
    output logic m_valid,
    input  logic m_ready,
    output logic m_hit,
    output logic [5:0] m_set_index,
    output logic [2:0] m_way,
    output logic m_evicted,
    output logic [31:0] m_hit_count,
    output logic [31:0] m_miss_count,
    input  logic cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data
);
    cmd_t cmd;
    stat_t stat;

    sacl_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_fire(s_valid && s_ready), .out_fire(m_valid && m_ready),
        .stat(stat), .cmd(cmd), .s_ready(s_ready), .m_valid(m_valid)
    );

    sacl_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .s_address(s_address), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .m_hit(m_hit), .m_set_index(m_set_index),
        .m_way(m_way), .m_evicted(m_evicted), .m_hit_count(m_hit_count),
        .m_miss_count(m_miss_count)
    );
endmodule

### src/sacl_checker.sv
`timescale 1ns / 1ps
`include "set_associative_cache_lookup_assert.svh"

module sacl_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_hit,
    input logic m_evicted,
    input logic [31:0] m_hit_count
);
    `SACL_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_valid, !s_ready)
    `SACL_ASSERT_IMP(a_hit_no_evict, aclk, aresetn, m_valid, !(m_hit && m_evicted))
    `SACL_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `SACL_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_valid && s_ready, !s_ready)
    `SACL_ASSERT_NEXT(a_count_hold, aclk, aresetn, m_valid && !m_ready,
        $stable(m_hit_count))
endmodule

bind set_associative_cache_lookup sacl_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit),
    .m_evicted(m_evicted), .m_hit_count(m_hit_count)
);

### tb/set_associative_cache_lookup_test.sv
`timescale 1ns / 1ps

module set_associative_cache_lookup_test;
    import sacl_pkg::*;

    // One expected result word.
    typedef struct {
        bit        hit;
        bit [5:0]  set_index;
        bit [2:0]  way;
        bit        evicted;
        bit [31:0] hit_count;
        bit [31:0] miss_count;
    } lookup_result_t;

    // Cache model plus the queue of lookup results still owed by the block.
    class lookup_scoreboard;
        bit [31:0] line_tag[LINES];
        bit        line_live[LINES];
        bit [2:0]  line_age[LINES];
        bit [15:0] line_uses[LINES];
        bit [31:0] hits;
        bit [31:0] misses;
        bit [3:0]  off_bits;
        bit [2:0]  set_bits;
        bit [3:0]  way_cfg;
        bit [1:0]  policy;
        lookup_result_t owed[$];
        int errors;

        function new();
            off_bits = 4;
            set_bits = 6;
            way_cfg = 8;
            policy = POL_LRU;
        endfunction

        function int live_ways();
            if (way_cfg == 0) return 1;
            if (way_cfg > WAYS) return WAYS;
            return way_cfg;
        endfunction

        function int live_set_bits();
            return (set_bits > SET_W) ? SET_W : set_bits;
        endfunction

        // Way w becomes the youngest among the valid ways in use.
        function void promote(int base, int w, int nw, bit was_live);
            int others;
            bit [2:0] old_age;
            others = 0;
            old_age = line_age[base + w];
            for (int i = 0; i < nw; i++) begin
                if (i == w || !line_live[base + i]) continue;
                if (was_live && line_age[base + i] > old_age)
                    line_age[base + i]--;
                others++;
            end
            line_age[base + w] = 3'(others);
        endfunction

        function void note_address(bit [31:0] addr);
            lookup_result_t r;
            bit [31:0] blk, tag;
            int ib, nw, set, base, w;
            bit [1:0] mode;
            bit hit, evict, found;
            ib = live_set_bits();
            nw = live_ways();
            mode = (policy == POL_SPARE) ? POL_LRU : policy;
            blk = addr >> off_bits;
            set = blk & ((32'd1 << ib) - 1);
            tag = blk >> ib;
            base = set * WAYS;
            hit = 0;
            evict = 0;
            found = 0;
            w = 0;
            for (int i = 0; i < nw; i++) begin
                if (!hit && line_live[base + i] && line_tag[base + i] == tag) begin
                    hit = 1;
                    w = i;
                end
            end
            if (hit) begin
                if (hits != '1) hits++;
                if (line_uses[base + w] != '1) line_uses[base + w]++;
                if (mode == POL_LRU) promote(base, w, nw, 1);
            end else begin
                if (misses != '1) misses++;
                for (int i = 0; i < nw; i++) begin
                    if (!found && !line_live[base + i]) begin
                        w = i;
                        found = 1;
                    end
                end
                if (!found) begin
                    evict = 1;
                    w = 0;
                    for (int i = 1; i < nw; i++) begin
                        if (mode == POL_LFU) begin
                            if (line_uses[base + i] < line_uses[base + w]) w = i;
                        end else begin
                            if (line_age[base + i] < line_age[base + w]) w = i;
                        end
                    end
                end
                line_live[base + w] = 1;
                line_tag[base + w] = tag;
                line_uses[base + w] = 1;
                promote(base, w, nw, evict);
            end
            r.hit = hit;
            r.set_index = 6'(set);
            r.way = 3'(w);
            r.evicted = evict;
            r.hit_count = hits;
            r.miss_count = misses;
            owed = {owed, r};
        endfunction

        function void check_result(bit hit, bit [5:0] set_index, bit [2:0] way,
                                   bit evicted, bit [31:0] hc, bit [31:0] mc);
            lookup_result_t e;
            if (owed.size() == 0) begin
                $error("result word with none expected");
                errors++;
                return;
            end
            e = owed.pop_front();
            if (hit != e.hit) begin
                $error("hit: expected %0d, got %0d", e.hit, hit); errors++;
            end
            if (set_index != e.set_index) begin
                $error("set_index: expected %0d, got %0d", e.set_index, set_index); errors++;
            end
            if (way != e.way) begin
                $error("way: expected %0d, got %0d", e.way, way); errors++;
            end
            if (evicted != e.evicted) begin
                $error("evicted: expected %0d, got %0d", e.evicted, evicted); errors++;
            end
            if (hc != e.hit_count) begin
                $error("hit_count: expected %0d, got %0d", e.hit_count, hc); errors++;
            end
            if (mc != e.miss_count) begin
                $error("miss_count: expected %0d, got %0d", e.miss_count, mc); errors++;
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [ADDRESS_BITS-1:0] s_address;
    logic m_valid;
    logic m_ready;
    logic m_hit;
    logic [5:0] m_set_index;
    logic [2:0] m_way;
    logic m_evicted;
    logic [31:0] m_hit_count;
    logic [31:0] m_miss_count;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [3:0] cfg_data;

    lookup_scoreboard sb;
    bit steady;

    set_associative_cache_lookup dut (.*);

    // Clock.
    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Result side stalls at random unless a steady stretch is running.
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 28);
    end

    // Check every result word taken.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_hit, m_set_index, m_way, m_evicted, m_hit_count, m_miss_count);
    end

    // Present one address word and hold it until accepted.
    task automatic send_address(bit [31:0] addr);
        while (!steady && $urandom_range(0, 99) < 28) begin
            s_valid <= 1'b0;
            s_address <= $urandom;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_address <= addr;
        do @(posedge aclk); while (!s_ready);
        sb.note_address(addr);
    endtask

    // Program all four registers once the block has drained.
    task automatic program_cache(bit [3:0] off, bit [3:0] idx, bit [3:0] nw, bit [3:0] pol);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_OFFSET; cfg_data <= off; @(posedge aclk);
        cfg_index <= CFG_INDEX; cfg_data <= idx; @(posedge aclk);
        cfg_index <= CFG_WAYS; cfg_data <= nw; @(posedge aclk);
        cfg_index <= CFG_POLICY; cfg_data <= pol; @(posedge aclk);
        cfg_we <= 1'b0;
        sb.off_bits = off;
        sb.set_bits = idx[2:0];
        sb.way_cfg = nw;
        sb.policy = pol[1:0];
    endtask

    // Mostly reuse a handful of tags in a few sets so hits and evictions pile up.
    function automatic bit [31:0] pick_address();
        bit [63:0] a;
        int ib;
        ib = sb.live_set_bits();
        if ($urandom_range(0, 99) < 25)
            return $urandom;
        a = 64'($urandom_range(0, sb.live_ways() + 2)) << (sb.off_bits + ib);
        a |= 64'($urandom_range(0, 3) & ((1 << ib) - 1)) << sb.off_bits;
        a |= 64'($urandom) & ((64'd1 << sb.off_bits) - 1);
        return a[31:0];
    endfunction

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        bit [3:0] phase_cfg[8][4] = '{
            '{4'd4, 4'd6, 4'd8, 4'd1}, '{4'd0, 4'd0, 4'd1, 4'd0},
            '{4'd12, 4'd6, 4'd8, 4'd2}, '{4'd15, 4'd7, 4'd15, 4'd3},
            '{4'd2, 4'd2, 4'd4, 4'd0}, '{4'd3, 4'd1, 4'd0, 4'd2},
            '{4'd5, 4'd3, 4'd3, 4'd1}, '{4'd9, 4'd5, 4'd6, 4'd0}};
        sb = new();
        steady = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_address = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_OFFSET;
        cfg_data = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int p = 0; p < 8; p++) begin
            program_cache(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
            steady = (p == 3);
            if (p == 0) begin
                // Extremes, a repeat hit, then nine tags in set 0 to force an eviction.
                send_address(32'h0000_0000);
                send_address(32'h0000_0000);
                send_address(32'hFFFF_FFFF);
                send_address(32'hFFFF_FFFF);
                for (int k = 1; k <= 9; k++)
                    send_address(k << 10);
                send_address(32'd5 << 10);
                send_address(32'h0000_000F);
            end
            for (int n = 0; n < 200; n++)
                send_address(pick_address());
        end
        s_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
